// File: rtl/core/scp_pkg.sv
// Shared definitions for the sensor command parser.
// Command kinds, command text tables, message state type and limits.
// No dependencies.
`timescale 1ns / 1ps

package scp_pkg;

   localparam int unsigned MAX_MSG_LEN_DEF = 1024;
   localparam int unsigned NUM_CMDS        = 6;
   localparam int unsigned PERIOD_MAX      = 3600;
   localparam int unsigned ACC_SAT         = 4095;
   localparam logic [11:0] PERIOD_RESET    = 12'd3;

   typedef enum logic [2:0] {
      KIND_OFF     = 3'd0,
      KIND_START   = 3'd1,
      KIND_STOP    = 3'd2,
      KIND_PERIOD  = 3'd3,
      KIND_SCALE   = 3'd4,
      KIND_DISPLAY = 3'd5,
      KIND_BAD     = 3'd6
   } kind_type;

   localparam logic [7:0] CHR_F     = 8'h46;
   localparam logic [7:0] CHR_C     = 8'h43;
   localparam logic [7:0] CHR_Y     = 8'h59;
   localparam logic [7:0] CHR_N     = 8'h4E;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;

   // Command text, one row per kind, padded with zero.
   localparam logic [7:0] PAT [NUM_CMDS][8] = '{
      '{8'h4F, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // OFF
      '{8'h53, 8'h54, 8'h41, 8'h52, 8'h54, 8'h00, 8'h00, 8'h00},  // START
      '{8'h53, 8'h54, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},  // STOP
      '{8'h50, 8'h45, 8'h52, 8'h49, 8'h4F, 8'h44, 8'h3D, 8'h00},  // PERIOD=
      '{8'h53, 8'h43, 8'h41, 8'h4C, 8'h45, 8'h3D, 8'h00, 8'h00},  // SCALE=
      '{8'h44, 8'h49, 8'h53, 8'h50, 8'h20, 8'h00, 8'h00, 8'h00}   // DISP
   };
   localparam int unsigned PAT_LEN [NUM_CMDS] = '{3, 5, 4, 7, 6, 5};
   // Bit per kind: text must match the whole message.
   localparam logic [NUM_CMDS-1:0] PAT_EXACT = 6'b000111;

   typedef struct packed {
      logic [NUM_CMDS-1:0] cands;
      logic [11:0]         accum;
      logic                digits_ok;
      logic [7:0]          opt_char;
   } msg_state_type;

   localparam msg_state_type MSG_CLEAR = '{
      cands:     {NUM_CMDS{1'b1}},
      accum:     12'd0,
      digits_ok: 1'b1,
      opt_char:  8'h00
   };

   typedef struct packed {
      kind_type kind;
      logic     ok;
      logic     opt_val;   // C for scale, Y for display
   } decision_type;

endpackage

// File: rtl/core/scp_decode.sv
// Per-beat matcher for the sensor command parser.
// Narrows the command candidates, collects digits and option letter,
// and decides the command on the last beat. Uses scp_pkg.
`timescale 1ns / 1ps

module scp_decode
   import scp_pkg::*;
#(
   parameter int unsigned MAX_MSG_LEN = MAX_MSG_LEN_DEF,
   localparam int unsigned POS_W      = $clog2(MAX_MSG_LEN + 1)
) (
   input  logic [7:0]     msg_byte,
   input  logic [POS_W-1:0] pos,
   input  msg_state_type  cur,
   output logic [POS_W-1:0] pos_nxt,
   output msg_state_type  nxt,
   output decision_type   dec
);

   logic        overlong;
   logic        is_digit;
   logic [15:0] acc_sum;
   logic        found;

   assign overlong = (pos == POS_W'(MAX_MSG_LEN));
   assign is_digit = (msg_byte >= CHR_ZERO) && (msg_byte <= CHR_NINE);
   assign acc_sum  = {4'd0, cur.accum} * 16'd10 + {12'd0, msg_byte[3:0]};

   always_comb begin
      nxt     = cur;
      pos_nxt = pos;
      if (!overlong) begin
         for (int i = 0; i < NUM_CMDS; i++) begin
            if (pos < POS_W'(PAT_LEN[i])) begin
               if (msg_byte != PAT[i][pos[2:0]]) begin
                  nxt.cands[i] = 1'b0;
               end
            end else if (PAT_EXACT[i]) begin
               nxt.cands[i] = 1'b0;
            end
         end
         if (pos == POS_W'(5) && nxt.cands[KIND_DISPLAY]) begin
            nxt.opt_char = msg_byte;
         end
         if (pos == POS_W'(6) && nxt.cands[KIND_SCALE]) begin
            nxt.opt_char = msg_byte;
         end
         if (pos >= POS_W'(7) && nxt.cands[KIND_PERIOD]) begin
            if (is_digit) begin
               nxt.accum = (acc_sum > 16'(ACC_SAT)) ? 12'(ACC_SAT) : acc_sum[11:0];
            end else begin
               nxt.digits_ok = 1'b0;
            end
         end
         pos_nxt = pos + POS_W'(1);
      end
   end

   always_comb begin
      dec   = '{kind: KIND_BAD, ok: 1'b0, opt_val: 1'b0};
      found = 1'b0;
      if (!overlong) begin
         // first surviving candidate whose length fits wins
         for (int i = 0; i < NUM_CMDS; i++) begin
            if (!found && nxt.cands[i] &&
                (PAT_EXACT[i] ? (pos == POS_W'(PAT_LEN[i] - 1))
                              : (pos >= POS_W'(PAT_LEN[i] - 1)))) begin
               found    = 1'b1;
               dec.kind = kind_type'(3'(i));
            end
         end
      end
      case (dec.kind)
         KIND_OFF, KIND_START, KIND_STOP: begin
            dec.ok = 1'b1;
         end
         KIND_PERIOD: begin
            dec.ok = nxt.digits_ok && (nxt.accum != 12'd0) &&
                     (nxt.accum <= 12'(PERIOD_MAX));
         end
         KIND_SCALE: begin
            dec.ok      = (pos == POS_W'(6)) &&
                          (nxt.opt_char == CHR_F || nxt.opt_char == CHR_C);
            dec.opt_val = (nxt.opt_char == CHR_C);
         end
         KIND_DISPLAY: begin
            dec.ok      = (pos == POS_W'(5)) &&
                          (nxt.opt_char == CHR_Y || nxt.opt_char == CHR_N);
            dec.opt_val = (nxt.opt_char == CHR_Y);
         end
         default: begin
            dec.ok = 1'b0;
         end
      endcase
   end

endmodule

// File: rtl/core/sensor_command_parser_top.sv
// Top level of the sensor command parser: handshakes, settings registers.
// Instantiates scp_decode; uses scp_pkg.
`timescale 1ns / 1ps

// Takes one message byte per cycle on the req_ channel while req_stall is
// low, and returns one response per message, on the beat flagged
// req_msg_last, with the command kind, whether it was applied, and the
// settings after it. Throughput is one beat per clock unless a last beat is
// held: a beat passes from the input register through the decode logic to
// the response register. Beats that end no message never wait on rsp_stall; a
// last beat waits only while the response register is full and stalled.
// After an OFF command every later beat is taken and dropped until reset.
module sensor_command_parser_top
   import scp_pkg::*;
#(
   parameter int unsigned MAX_MSG_LEN = MAX_MSG_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_msg_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_cmd_kind,
   output logic        rsp_accepted,
   output logic [11:0] rsp_period_secs,
   output logic        rsp_scale_celsius,
   output logic        rsp_display_on,
   output logic        rsp_sending,
   output logic        rsp_powered_off
);

   localparam int unsigned POS_W = $clog2(MAX_MSG_LEN + 1);

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   logic [POS_W-1:0]   pos_ff, pos_in, pos_dec;
   msg_state_type      msg_ff, msg_in, msg_dec;
   decision_type       dec;
   logic [11:0]        period_ff, period_in;
   logic               celsius_ff, celsius_in;
   logic               display_ff, display_in;
   logic               sending_ff, sending_in;
   logic               off_ff, off_in;
   logic               rsp_valid_ff;
   logic [2:0]         kind_ff;
   logic               ok_ff;
   logic [11:0]        rsp_period_ff;
   logic               rsp_celsius_ff, rsp_display_ff, rsp_sending_ff, rsp_off_ff;
   logic               advance;
   logic               emit;

   scp_decode #(.MAX_MSG_LEN(MAX_MSG_LEN)) u_decode (
      .msg_byte (in_byte_ff),
      .pos      (pos_ff),
      .cur      (msg_ff),
      .pos_nxt  (pos_dec),
      .nxt      (msg_dec),
      .dec      (dec)
   );

   assign advance = in_valid_ff &&
                    (!in_last_ff || off_ff || !rsp_valid_ff || !rsp_stall);
   assign emit    = advance && in_last_ff && !off_ff;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      pos_in     = pos_ff;
      msg_in     = msg_ff;
      period_in  = period_ff;
      celsius_in = celsius_ff;
      display_in = display_ff;
      sending_in = sending_ff;
      off_in     = off_ff;
      if (advance && !off_ff) begin
         if (in_last_ff) begin
            pos_in = '0;
            msg_in = MSG_CLEAR;
            if (dec.ok) begin
               case (dec.kind)
                  KIND_OFF:     off_in     = 1'b1;
                  KIND_START:   sending_in = 1'b1;
                  KIND_STOP:    sending_in = 1'b0;
                  KIND_PERIOD:  period_in  = msg_dec.accum;
                  KIND_SCALE:   celsius_in = dec.opt_val;
                  KIND_DISPLAY: display_in = dec.opt_val;
                  default:      off_in     = off_ff;
               endcase
            end
         end else begin
            pos_in = pos_dec;
            msg_in = msg_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         msg_ff       <= MSG_CLEAR;
         period_ff    <= PERIOD_RESET;
         celsius_ff   <= 1'b0;
         display_ff   <= 1'b1;
         sending_ff   <= 1'b1;
         off_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         pos_ff     <= pos_in;
         msg_ff     <= msg_in;
         period_ff  <= period_in;
         celsius_ff <= celsius_in;
         display_ff <= display_in;
         sending_ff <= sending_in;
         off_ff     <= off_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: hold unless a new beat loads them
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_msg_byte;
         in_last_ff <= req_msg_last;
      end
      if (emit) begin
         kind_ff        <= dec.kind;
         ok_ff          <= dec.ok;
         rsp_period_ff  <= period_in;
         rsp_celsius_ff <= celsius_in;
         rsp_display_ff <= display_in;
         rsp_sending_ff <= sending_in;
         rsp_off_ff     <= off_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cmd_kind      = kind_ff;
   assign rsp_accepted      = ok_ff;
   assign rsp_period_secs   = rsp_period_ff;
   assign rsp_scale_celsius = rsp_celsius_ff;
   assign rsp_display_on    = rsp_display_ff;
   assign rsp_sending       = rsp_sending_ff;
   assign rsp_powered_off   = rsp_off_ff;

   a_off_sticky: assert property (@(posedge clock) disable iff (reset)
      off_ff |=> off_ff)
      else $error("power-off flag cleared without reset");

   a_no_rsp_after_off: assert property (@(posedge clock) disable iff (reset)
      off_ff && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response issued after power-off");

   a_period_range: assert property (@(posedge clock) disable iff (reset)
      period_ff != 12'd0 && period_ff <= 12'(PERIOD_MAX))
      else $error("period setting out of range");

   a_bad_not_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_BAD |-> !ok_ff)
      else $error("unrecognized command reported as accepted");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_MSG_LEN))
      else $error("byte position past saturation");

endmodule

// File: tb/sensor_command_parser_checker.sv
// Response checker for the sensor command parser: watches the req_ and rsp_
// channels, predicts each response from the accepted bytes and compares it.
// Uses scp_pkg for the command kind type and the message length limit.
`timescale 1ns / 1ps

module sensor_command_parser_checker
   import scp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_msg_byte,
   input  logic        req_msg_last,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_cmd_kind,
   input  logic        rsp_accepted,
   input  logic [11:0] rsp_period_secs,
   input  logic        rsp_scale_celsius,
   input  logic        rsp_display_on,
   input  logic        rsp_sending,
   input  logic        rsp_powered_off,
   output int          errors,
   output int          waiting,
   output int          responses
);

   localparam int MSG_LIMIT  = MAX_MSG_LEN_DEF;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      kind_type    kind;
      logic        ok;
      logic [11:0] period;
      logic        celsius;
      logic        display;
      logic        sending;
      logic        off;
   } parser_report;

   parser_report reports_due[$];

   // per-message matching state
   int          msg_pos;
   logic [5:0]  cand_mask;
   int          digit_acc;
   logic        digits_ok;
   logic [7:0]  opt_char;

   // settings held across messages
   logic [11:0] cur_period;
   logic        cur_celsius;
   logic        cur_display;
   logic        cur_sending;
   logic        cur_off;

   int err_n = 0;
   int rsp_n = 0;

   // command text by kind; the first three must match the whole message
   function automatic string cmd_text(int k);
      case (k)
         0:       return "OFF";
         1:       return "START";
         2:       return "STOP";
         3:       return "PERIOD=";
         4:       return "SCALE=";
         default: return "DISP ";
      endcase
   endfunction

   function automatic void clear_msg();
      msg_pos   = 0;
      cand_mask = 6'b111111;
      digit_acc = 0;
      digits_ok = 1'b1;
      opt_char  = 8'h00;
   endfunction

   function automatic void reset_settings();
      clear_msg();
      cur_period  = 12'd3;
      cur_celsius = 1'b0;
      cur_display = 1'b1;
      cur_sending = 1'b1;
      cur_off     = 1'b0;
   endfunction

   task automatic parse_beat(input logic [7:0] b, input logic last);
      int           p;
      int           len;
      int           i;
      bit           overlong;
      bit           found;
      bit           ok;
      string        t;
      kind_type     kind;
      parser_report rep;
      p        = msg_pos;
      overlong = (p >= MSG_LIMIT);
      ok       = 1'b0;
      found    = 1'b0;
      kind     = KIND_BAD;
      if (cur_off) return;
      if (!overlong) begin
         for (i = 0; i < 6; i++) begin
            t = cmd_text(i);
            if (cand_mask[i]) begin
               if (p < t.len()) begin
                  if (b != t[p]) cand_mask[i] = 1'b0;
               end else if (i < 3) begin
                  cand_mask[i] = 1'b0;
               end
            end
         end
         if (p == 5 && cand_mask[5]) opt_char = b;
         if (p == 6 && cand_mask[4]) opt_char = b;
         if (p >= 7 && cand_mask[3]) begin
            if (b >= "0" && b <= "9") begin
               digit_acc = digit_acc * 10 + int'(b - "0");
               if (digit_acc > 4095) digit_acc = 4095;
            end else begin
               digits_ok = 1'b0;
            end
         end
         msg_pos = p + 1;
      end
      if (!last) return;
      len = p + 1;
      if (!overlong) begin
         for (i = 0; i < 6; i++) begin
            t = cmd_text(i);
            if (!found && cand_mask[i] &&
                ((i < 3) ? (len == t.len()) : (len >= t.len()))) begin
               kind  = kind_type'(i);
               found = 1'b1;
            end
         end
      end
      case (kind)
         KIND_OFF: begin
            cur_off = 1'b1;
            ok      = 1'b1;
         end
         KIND_START: begin
            cur_sending = 1'b1;
            ok          = 1'b1;
         end
         KIND_STOP: begin
            cur_sending = 1'b0;
            ok          = 1'b1;
         end
         KIND_PERIOD: begin
            if (digits_ok && digit_acc >= 1 && digit_acc <= 3600) begin
               cur_period = 12'(digit_acc);
               ok         = 1'b1;
            end
         end
         KIND_SCALE: begin
            if (len == 7 && (opt_char == "F" || opt_char == "C")) begin
               cur_celsius = (opt_char == "C");
               ok          = 1'b1;
            end
         end
         KIND_DISPLAY: begin
            if (len == 6 && (opt_char == "Y" || opt_char == "N")) begin
               cur_display = (opt_char == "Y");
               ok          = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rep.kind    = kind;
      rep.ok      = ok;
      rep.period  = cur_period;
      rep.celsius = cur_celsius;
      rep.display = cur_display;
      rep.sending = cur_sending;
      rep.off     = cur_off;
      reports_due.push_back(rep);
      clear_msg();
   endtask

   always @(posedge clock) begin : watch
      parser_report got;
      parser_report want;
      if (reset) begin
         reset_settings();
         reports_due.delete();
      end else begin
         // check the outgoing beat before predicting, so a fresh expectation
         // can never cover an unexpected response
         if (rsp_valid && !rsp_stall) begin
            got.kind    = kind_type'(rsp_cmd_kind);
            got.ok      = rsp_accepted;
            got.period  = rsp_period_secs;
            got.celsius = rsp_scale_celsius;
            got.display = rsp_display_on;
            got.sending = rsp_sending;
            got.off     = rsp_powered_off;
            rsp_n++;
            if (reports_due.size() == 0) begin
               if (err_n < REPORT_MAX)
                  $display("%0t: unexpected response kind %0d ok %0b period %0d",
                           $realtime, got.kind, got.ok, got.period);
               err_n++;
            end else begin
               want = reports_due.pop_front();
               if (got !== want) begin
                  if (err_n < REPORT_MAX) begin
                     $display("%0t: mismatch expected kind %0d ok %0b period %0d C %0b disp %0b send %0b off %0b",
                              $realtime, want.kind, want.ok, want.period, want.celsius,
                              want.display, want.sending, want.off);
                     $display("%0t:               got kind %0d ok %0b period %0d C %0b disp %0b send %0b off %0b",
                              $realtime, got.kind, got.ok, got.period, got.celsius,
                              got.display, got.sending, got.off);
                  end
                  err_n++;
               end
            end
         end
         if (req_valid && !req_stall)
            parse_beat(req_msg_byte, req_msg_last);
      end
      errors    <= err_n;
      responses <= rsp_n;
      waiting   <= reports_due.size();
   end

endmodule

// File: tb/tb_sensor_command_parser_top.sv
// Testbench top for the sensor command parser: clock, reset, byte stimulus,
// response back-pressure, watchdog and verdict.
// Depends on sensor_command_parser_top, sensor_command_parser_checker, scp_pkg.
`timescale 1ns / 1ps

module tb_sensor_command_parser_top;
   import scp_pkg::*;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 12;
   localparam int HOLD_CYCLES   = 200;
   localparam int QUIET_LIMIT   = 2000;
   localparam int END_CYCLES    = 8;
   localparam int PHASE_BEATS   = 170;
   localparam int BURST_MSGS    = 16;
   localparam int AFTER_OFF     = 24;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [7:0]  req_msg_byte = 8'h00;
   logic        req_msg_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic [2:0]  rsp_cmd_kind;
   logic        rsp_accepted;
   logic [11:0] rsp_period_secs;
   logic        rsp_scale_celsius;
   logic        rsp_display_on;
   logic        rsp_sending;
   logic        rsp_powered_off;

   int errors;
   int waiting;
   int responses;

   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int beats_sent    = 0;
   int msgs_sent     = 0;

   logic [7:0] msg_q[$];

   sensor_command_parser_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_msg_byte      (req_msg_byte),
      .req_msg_last      (req_msg_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cmd_kind      (rsp_cmd_kind),
      .rsp_accepted      (rsp_accepted),
      .rsp_period_secs   (rsp_period_secs),
      .rsp_scale_celsius (rsp_scale_celsius),
      .rsp_display_on    (rsp_display_on),
      .rsp_sending       (rsp_sending),
      .rsp_powered_off   (rsp_powered_off)
   );

   sensor_command_parser_checker parser_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_msg_byte      (req_msg_byte),
      .req_msg_last      (req_msg_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cmd_kind      (rsp_cmd_kind),
      .rsp_accepted      (rsp_accepted),
      .rsp_period_secs   (rsp_period_secs),
      .rsp_scale_celsius (rsp_scale_celsius),
      .rsp_display_on    (rsp_display_on),
      .rsp_sending       (rsp_sending),
      .rsp_powered_off   (rsp_powered_off),
      .errors            (errors),
      .waiting           (waiting),
      .responses         (responses)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // response side: random stall, or a long hold-off when one is requested
   initial begin : receiver
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_sensor_command_parser_top: errors");
      $finish;
   end

   task automatic send_beat(input logic [7:0] b, input logic last);
      // idle with junk on the payload while valid is low
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid    <= 1'b0;
         req_msg_byte <= 8'($urandom_range(0, 255));
         req_msg_last <= 1'($urandom_range(0, 1));
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_msg_byte <= b;
      req_msg_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_msg();
      int i;
      for (i = 0; i < msg_q.size(); i++)
         send_beat(msg_q[i], i == msg_q.size() - 1);
      msg_q.delete();
      msgs_sent++;
   endtask

   task automatic add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         msg_q.push_back(s[i]);
   endtask

   task automatic send_text(input string s);
      add_text(s);
      send_msg();
   endtask

   // hold the sender until every outstanding response has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] non_digit();
      int v;
      v = $urandom_range(0, 245);
      return (v < 48) ? 8'(v) : 8'(v + 10);
   endfunction

   task automatic build_random_msg();
      int sel;
      int n;
      sel = $urandom_range(0, 19);
      case (sel)
         0, 1: add_text((sel == 0) ? "START" : "STOP");
         2, 3, 4, 5: begin
            add_text("PERIOD=");
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) add_text("0");
            add_text($sformatf("%0d", $urandom_range(1, 3600)));
         end
         6: begin
            add_text("PERIOD=");
            case ($urandom_range(0, 4))
               0: add_text("0");
               1: add_text($sformatf("%0d", $urandom_range(3601, 4095)));
               2: add_text($sformatf("%0d", $urandom_range(4096, 999999)));
               3: begin
               end
               default: begin
                  add_text($sformatf("%0d", $urandom_range(1, 3600)));
                  msg_q.insert($urandom_range(7, msg_q.size()), non_digit());
               end
            endcase
         end
         7, 8: add_text($urandom_range(0, 1) ? "SCALE=C" : "SCALE=F");
         9: begin
            add_text("SCALE=");
            case ($urandom_range(0, 2))
               0: begin
               end
               1: add_text($urandom_range(0, 1) ? "CF" : "FF");
               default: msg_q.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         10, 11: add_text($urandom_range(0, 1) ? "DISP Y" : "DISP N");
         12: begin
            add_text("DISP ");
            case ($urandom_range(0, 2))
               0: begin
               end
               1: add_text($urandom_range(0, 1) ? "YN" : "NN");
               default: msg_q.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         13, 14, 15: begin
            // broken command: truncate, overwrite or extend a good one
            case ($urandom_range(0, 5))
               0: add_text("OFF");
               1: add_text("START");
               2: add_text("STOP");
               3: add_text("PERIOD=12");
               4: add_text("SCALE=C");
               default: add_text("DISP Y");
            endcase
            case ($urandom_range(0, 2))
               0: begin
                  n = $urandom_range(1, msg_q.size() - 1);
                  while (msg_q.size() > n) void'(msg_q.pop_back());
               end
               1: msg_q[$urandom_range(0, msg_q.size() - 1)] = 8'($urandom_range(0, 255));
               default: msg_q.push_back(8'($urandom_range(0, 255)));
            endcase
         end
         16, 17: repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom_range(0, 255)));
         default: msg_q.push_back(8'($urandom_range(0, 255)));
      endcase
      // power-off is sticky, so keep it for the very end
      if (msg_q.size() == 3 && msg_q[0] == "O" && msg_q[1] == "F" && msg_q[2] == "F")
         msg_q.push_back("F");
   endtask

   task automatic run_directed();
      int i;
      send_text("START");
      send_text("STOP");
      send_text("PERIOD=1");
      send_text("PERIOD=3600");
      send_text("PERIOD=3601");
      send_text("PERIOD=0");
      send_text("PERIOD=");
      send_text("PERIOD=0007");
      send_text("PERIOD=999999999");
      send_text("PERIOD=12a");
      send_text("SCALE=C");
      send_text("SCALE=F");
      send_text("SCALE=X");
      send_text("SCALE=CC");
      send_text("DISP N");
      send_text("DISP Y");
      send_text("DISP ");
      send_text("DISP YY");
      send_text("STARTS");
      send_text("OF");
      msg_q.push_back(8'h00);
      send_msg();
      add_text("STOP");
      msg_q.push_back(8'h00);
      send_msg();
      msg_q.push_back(8'hFF);
      send_msg();
      // longest legal message, then one longer than the limit
      add_text("PERIOD=");
      for (i = 0; i < MAX_MSG_LEN_DEF - 9; i++) add_text("0");
      add_text("42");
      send_msg();
      add_text("START");
      for (i = 0; i < MAX_MSG_LEN_DEF + 1; i++) msg_q.push_back(8'($urandom_range(0, 255)));
      send_msg();
      send_text("PERIOD=5");
   endtask

   initial begin : stimulus
      int ph;
      int start_beats;
      int i;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      idle_pct  = 34;
      stall_pct = 65;
      run_directed();
      drain();
      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               idle_pct  = 34;
               stall_pct = 65;
            end
            1: begin
               idle_pct  = 65;
               stall_pct = 34;
            end
            default: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
         endcase
         start_beats = beats_sent;
         while (beats_sent - start_beats < PHASE_BEATS) begin
            build_random_msg();
            send_msg();
         end
         drain();
         if (ph == 0) begin
            // back up the pipeline with one-byte messages behind a long hold
            idle_pct = 0;
            hold_requests++;
            for (i = 0; i < BURST_MSGS; i++) begin
               msg_q.push_back(8'($urandom_range(0, 255)));
               send_msg();
            end
            drain();
         end
      end
      idle_pct  = 34;
      stall_pct = 34;
      send_text("OFF");
      // everything after power-off must be swallowed
      for (i = 0; i < AFTER_OFF; i++)
         send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);
      drain();
      repeat (END_CYCLES) @(posedge clock);
      $display("Run: %0d beats in %0d messages, %0d responses compared.",
               beats_sent, msgs_sent, responses);
      $display("Covered every command, period bounds, maximal and overlong messages, a hold-off, and power-off.");
      if (errors == 0 && waiting == 0)
         $display("tb_sensor_command_parser_top: clean");
      else
         $display("tb_sensor_command_parser_top: errors");
      $finish;
   end

endmodule
